FILE: rtl/core/mean_relative_difference_assert.svh
// assertion macros shared by the mean relative difference rtl
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef MEAN_RELATIVE_DIFFERENCE_ASSERT_SVH
`define MEAN_RELATIVE_DIFFERENCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clock, off while reset is high
`define MRD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, clocked on clock, off while reset is high
`define MRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MRD_ASSERT_IMPL(label, ante, cons, msg)
`define MRD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/mrd_pkg.sv
// shared types and constants of the mean relative difference block
// no dependencies; used by the channel interfaces, the divider and the top level
package mrd_pkg;

   // default parameter values
   localparam int DEFAULT_MAX_ELEMENTS = 1048576;
   localparam int DEFAULT_DATA_WIDTH   = 32;

   // fixed field widths
   localparam int CFG_WIDTH   = 21;
   localparam int RATIO_WIDTH = 24;
   localparam int SUM_WIDTH   = 44;
   // extra fraction bits: ratio is 2*|e-r|/|e+r| in q8.16
   localparam int FRAC_BITS   = 17;

   localparam logic [RATIO_WIDTH-1:0] RATIO_MAX = '1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABS,
      ST_RATIO_START,
      ST_RATIO_WAIT,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_OUT
   } mrd_state_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mrd_div_status_type;

endpackage

FILE: rtl/core/mrd_if.sv
// valid/ready channel interfaces of the mean relative difference block
// depends on mrd_pkg for default widths
interface mrd_req_if #(
   parameter int DATA_WIDTH = mrd_pkg::DEFAULT_DATA_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] reference_value;
   logic signed [DATA_WIDTH-1:0] evaluated_value;
   logic                         last_element;

   modport source (output valid, output reference_value, output evaluated_value,
                   output last_element, input ready);
   modport sink   (input valid, input reference_value, input evaluated_value,
                   input last_element, output ready);
endinterface

interface mrd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mrd_pkg::RATIO_WIDTH-1:0]    mean_ratio;
   logic                               division_error;

   modport source (output valid, output mean_ratio, output division_error, input ready);
   modport sink   (input valid, input mean_ratio, input division_error, output ready);
endinterface

interface mrd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mrd_pkg::CFG_WIDTH-1:0]   average_count;

   modport source (output valid, output average_count, input ready);
   modport sink   (input valid, input average_count, output ready);
endinterface

FILE: rtl/core/mrd_divider.sv
// shared restoring divider: 24 quotient bits, one bit per cycle, saturating
// depends on mrd_pkg; used by mean_relative_difference for ratio and mean
module mrd_divider #(
   parameter int NUM_WIDTH = 50,
   parameter int DEN_WIDTH = 33
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [NUM_WIDTH-1:0]              num,
   input  logic [DEN_WIDTH-1:0]              den,
   output mrd_pkg::mrd_div_status_type       status,
   output logic [mrd_pkg::RATIO_WIDTH-1:0]   quotient
);

   localparam int QW    = mrd_pkg::RATIO_WIDTH;
   localparam int HI_W  = NUM_WIDTH - QW;
   localparam int REM_W = (HI_W > DEN_WIDTH + 1) ? HI_W : DEN_WIDTH + 1;
   localparam int CNT_W = $clog2(QW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QW-1:0]        low_ff, low_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [QW-1:0]        quot_ff, quot_in;

   logic [REM_W-1:0]     start_hi;
   logic                 start_sat;
   logic [REM_W-1:0]     step_trial;
   logic [REM_W-1:0]     step_diff;
   logic                 step_ge;

   // overflow check at load and one restoring step per cycle
   always_comb begin
      start_hi   = REM_W'(num[NUM_WIDTH-1:QW]);
      start_sat  = start_hi >= REM_W'(den);
      step_trial = {rem_ff[REM_W-2:0], low_ff[QW-1]};
      step_ge    = step_trial >= REM_W'(den_ff);
      step_diff  = step_trial - REM_W'(den_ff);

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      quot_in = quot_ff;

      if (start) begin
         den_in = den;
         if (start_sat) begin
            quot_in = mrd_pkg::RATIO_MAX;
            done_in = 1'b1;
         end else begin
            rem_in = start_hi;
            low_in = num[QW-1:0];
            run_in = 1'b1;
            cnt_in = '0;
         end
      end else if (run_ff) begin
         rem_in  = step_ge ? step_diff : step_trial;
         low_in  = {low_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], step_ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

FILE: rtl/core/mean_relative_difference.sv
// Pairs are handled one at a time: a new pair is accepted only in idle, once the last one is
// through the single shared 1-bit-per-cycle divider; a saturated ratio ends the division at
// load and a zero divisor skips it. Last pair: a second 24-step division forms the mean, and
// the result beat is registered once it is done and the result register is free. The result
// register lets the next pair in while a result waits. Synchronous active-high reset clears
// sum, count, flag and register.
`include "mean_relative_difference_assert.svh"
module mean_relative_difference #(
   parameter int MAX_ELEMENTS = mrd_pkg::DEFAULT_MAX_ELEMENTS,
   parameter int DATA_WIDTH   = mrd_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   mrd_req_if.sink    req_ch,
   mrd_rsp_if.source  rsp_ch,
   mrd_csr_if.sink    csr_ch
);

   localparam int DIFF_W = DATA_WIDTH + 1;
   localparam int SUM_W  = mrd_pkg::SUM_WIDTH;
   localparam int CFG_W  = mrd_pkg::CFG_WIDTH;
   localparam int QW     = mrd_pkg::RATIO_WIDTH;
   localparam int FRAC   = mrd_pkg::FRAC_BITS;
   localparam int CW     = $clog2(MAX_ELEMENTS + 1);
   localparam int CMW    = (CFG_W > CW) ? CFG_W : CW;
   localparam int NUM_W  = (DIFF_W + FRAC > SUM_W) ? DIFF_W + FRAC : SUM_W;
   localparam int DEN_W  = (DIFF_W > CW) ? DIFF_W : CW;

   mrd_pkg::mrd_state_type state_ff, state_in;

   logic signed [DIFF_W-1:0] d_ff, d_in;
   logic signed [DIFF_W-1:0] s_ff, s_in;
   logic [DIFF_W-1:0]        ad_ff, ad_in;
   logic [DIFF_W-1:0]        as_ff, as_in;
   logic                     last_ff, last_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [CW-1:0]            items_ff, items_in;
   logic                     err_ff, err_in;
   logic [CFG_W-1:0]         avg_ff, avg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0]            rsp_mean_ff, rsp_mean_in;
   logic                     rsp_err_ff, rsp_err_in;

   logic                         div_start;
   logic [NUM_W-1:0]             div_num;
   logic [DEN_W-1:0]             div_den;
   mrd_pkg::mrd_div_status_type  div_status;
   logic [QW-1:0]                div_quot;

   logic [SUM_W:0]   sum_wide;
   logic [CMW-1:0]   cfg_ext;
   logic [CMW-1:0]   cfg_clamp;
   logic [CW-1:0]    mean_cnt;

   logic             at_out;
   logic             out_fire;
   logic             div_waiting;
   logic             set_clear;

   // shared divider for the per-pair ratio and the final mean
   mrd_divider #(
      .NUM_WIDTH (NUM_W),
      .DEN_WIDTH (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .status   (div_status),
      .quotient (div_quot)
   );

   // mean divisor: clamped register, else items seen, never zero
   always_comb begin
      cfg_ext   = CMW'(avg_ff);
      cfg_clamp = (cfg_ext > CMW'(MAX_ELEMENTS)) ? CMW'(MAX_ELEMENTS) : cfg_ext;
      mean_cnt  = CW'(cfg_clamp);
      if (mean_cnt == '0) begin
         mean_cnt = items_ff;
      end
      if (mean_cnt == '0) begin
         mean_cnt = CW'(1);
      end
   end

   // divider operands and saturating sum
   always_comb begin
      if (state_ff == mrd_pkg::ST_MEAN_START) begin
         div_num = NUM_W'(sum_ff);
         div_den = DEN_W'(mean_cnt);
      end else begin
         div_num = NUM_W'({ad_ff, {FRAC{1'b0}}});
         div_den = DEN_W'(as_ff);
      end
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(div_quot);
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      ad_in        = ad_ff;
      as_in        = as_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      items_in     = items_ff;
      err_in       = err_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_err_in   = rsp_err_ff;
      div_start    = 1'b0;

      if (csr_ch.valid) begin
         avg_in = csr_ch.average_count;
      end

      case (state_ff)
         mrd_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               d_in     = DIFF_W'(req_ch.evaluated_value) - DIFF_W'(req_ch.reference_value);
               s_in     = DIFF_W'(req_ch.evaluated_value) + DIFF_W'(req_ch.reference_value);
               last_in  = req_ch.last_element;
               state_in = mrd_pkg::ST_ABS;
            end
         end
         mrd_pkg::ST_ABS: begin
            ad_in = d_ff[DIFF_W-1] ? $unsigned(-d_ff) : $unsigned(d_ff);
            as_in = s_ff[DIFF_W-1] ? $unsigned(-s_ff) : $unsigned(s_ff);
            if (items_ff < CW'(MAX_ELEMENTS)) begin
               items_in = items_ff + CW'(1);
            end
            if (s_ff == '0) begin
               if (d_ff != '0) begin
                  err_in = 1'b1;
               end
               state_in = last_ff ? mrd_pkg::ST_MEAN_START : mrd_pkg::ST_IDLE;
            end else begin
               state_in = mrd_pkg::ST_RATIO_START;
            end
         end
         mrd_pkg::ST_RATIO_START: begin
            div_start = 1'b1;
            state_in  = mrd_pkg::ST_RATIO_WAIT;
         end
         mrd_pkg::ST_RATIO_WAIT: begin
            if (div_status.done) begin
               sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
               state_in = last_ff ? mrd_pkg::ST_MEAN_START : mrd_pkg::ST_IDLE;
            end
         end
         mrd_pkg::ST_MEAN_START: begin
            div_start = 1'b1;
            state_in  = mrd_pkg::ST_MEAN_WAIT;
         end
         mrd_pkg::ST_MEAN_WAIT: begin
            if (div_status.done) begin
               state_in = mrd_pkg::ST_OUT;
            end
         end
         mrd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = err_ff ? '0 : div_quot;
               rsp_err_in   = err_ff;
               sum_in       = '0;
               items_in     = '0;
               err_in       = 1'b0;
               state_in     = mrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrd_pkg::ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrd_pkg::ST_IDLE;
         sum_ff       <= '0;
         items_ff     <= '0;
         err_ff       <= 1'b0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         items_ff     <= items_in;
         err_ff       <= err_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      s_ff        <= s_in;
      ad_ff       <= ad_in;
      as_ff       <= as_in;
      last_ff     <= last_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // channel outputs
   assign req_ch.ready          = (state_ff == mrd_pkg::ST_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.mean_ratio     = rsp_mean_ff;
   assign rsp_ch.division_error = rsp_err_ff;

   // conditions named for the checks
   always_comb begin
      at_out      = (state_ff == mrd_pkg::ST_OUT);
      out_fire    = at_out && (state_in == mrd_pkg::ST_IDLE);
      div_waiting = (state_ff == mrd_pkg::ST_RATIO_WAIT) ||
                    (state_ff == mrd_pkg::ST_MEAN_WAIT);
      set_clear   = (sum_ff == '0) && (items_ff == '0) && !err_ff;
   end

   // checks
   `MRD_ASSERT_IMPL(a_start_idle_div, div_start, !div_status.busy, "divider restarted while busy")
   `MRD_ASSERT_IMPL(a_done_in_wait, div_status.done, div_waiting, "divider done outside a wait")
   `MRD_ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid_ff), $past(at_out), "stray result beat")
   `MRD_ASSERT_NEXT(a_clear_after_out, out_fire, set_clear, "set state not cleared after result")
   `MRD_ASSERT_IMPL(a_err_zero_mean, rsp_err_ff, rsp_mean_ff == '0, "nonzero mean on error")

endmodule

FILE: test/mrd_checker.sv
// checker for the mean relative difference block: follows every beat on the three channels,
// works out each expected mean and compares it with the result beat
// depends on mrd_pkg and the channel interfaces of mrd_if
module mrd_checker (
   input  logic clock,
   input  logic reset,
   mrd_req_if   req_ch,
   mrd_rsp_if   rsp_ch,
   mrd_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);

   localparam logic [mrd_pkg::SUM_WIDTH-1:0] SUM_MAX = '1;

   typedef logic signed [mrd_pkg::DEFAULT_DATA_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic [mrd_pkg::RATIO_WIDTH-1:0] mean_ratio;
      logic                            division_error;
   } mean_result_type;

   // means still owed by the block, oldest first
   mean_result_type                 owed_means[$];

   // own copy of the accumulator state and the count register
   logic [mrd_pkg::SUM_WIDTH-1:0]   ratio_total;
   logic [mrd_pkg::CFG_WIDTH-1:0]   pairs_in_set;
   logic                            nan_seen;
   logic [mrd_pkg::CFG_WIDTH-1:0]   mean_divisor;

   // q8.16 value of 2*|e-r|/|e+r|, truncated and saturated; sum_mag is never 0
   function automatic logic [mrd_pkg::RATIO_WIDTH-1:0] pair_ratio(input logic [63:0] diff_mag,
                                                                  input logic [63:0] sum_mag);
      logic [63:0] quot;
      if (diff_mag >= (sum_mag << 7))
         return mrd_pkg::RATIO_MAX;
      quot = (diff_mag << mrd_pkg::FRAC_BITS) / sum_mag;
      return quot[mrd_pkg::RATIO_WIDTH-1:0];
   endfunction

   // fold one pair into the running sum, and on the last pair owe a mean
   task automatic accumulate_pair(input sample_type ref_s, input sample_type eval_s,
                                  input logic last);
      longint          ref_l;
      longint          eval_l;
      longint          diff;
      longint          total;
      logic [63:0]     diff_mag;
      logic [63:0]     sum_mag;
      logic [63:0]     widened;
      logic [63:0]     divisor;
      mean_result_type owed;
      ref_l    = ref_s;
      eval_l   = eval_s;
      diff     = eval_l - ref_l;
      total    = eval_l + ref_l;
      diff_mag = (diff < 0) ? -diff : diff;
      sum_mag  = (total < 0) ? -total : total;

      // zero divisor adds nothing; with a nonzero difference it flags an error
      if (sum_mag != 0) begin
         widened     = 64'(ratio_total) + 64'(pair_ratio(diff_mag, sum_mag));
         ratio_total = (widened > 64'(SUM_MAX)) ? SUM_MAX
                                                : widened[mrd_pkg::SUM_WIDTH-1:0];
      end else if (diff_mag != 0) begin
         nan_seen = 1'b1;
      end
      if (pairs_in_set < mrd_pkg::DEFAULT_MAX_ELEMENTS)
         pairs_in_set = pairs_in_set + 1'b1;

      if (last) begin
         // count register clamped, 0 selects the pairs seen
         divisor = (64'(mean_divisor) > 64'(mrd_pkg::DEFAULT_MAX_ELEMENTS)) ?
                   64'(mrd_pkg::DEFAULT_MAX_ELEMENTS) : 64'(mean_divisor);
         if (divisor == 0)
            divisor = 64'(pairs_in_set);
         if (divisor == 0)
            divisor = 64'd1;
         widened = 64'(ratio_total) / divisor;
         if (widened > 64'(mrd_pkg::RATIO_MAX))
            widened = 64'(mrd_pkg::RATIO_MAX);
         owed.mean_ratio     = nan_seen ? '0 : widened[mrd_pkg::RATIO_WIDTH-1:0];
         owed.division_error = nan_seen;
         owed_means.push_back(owed);
         ratio_total  = '0;
         pairs_in_set = '0;
         nan_seen     = 1'b0;
      end
   endtask

   // compare a result beat with the oldest owed mean
   task automatic check_result();
      mean_result_type want;
      if (owed_means.size() == 0) begin
         $display("%0t: result beat with nothing owed, mean_ratio %h division_error %b",
                  $time, rsp_ch.mean_ratio, rsp_ch.division_error);
         fail_count++;
      end else begin
         want = owed_means.pop_front();
         if (rsp_ch.mean_ratio !== want.mean_ratio) begin
            $display("%0t: mean_ratio expected %h actual %h",
                     $time, want.mean_ratio, rsp_ch.mean_ratio);
            fail_count++;
         end
         if (rsp_ch.division_error !== want.division_error) begin
            $display("%0t: division_error expected %b actual %b",
                     $time, want.division_error, rsp_ch.division_error);
            fail_count++;
         end
      end
   endtask

   // sample all channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         ratio_total  = '0;
         pairs_in_set = '0;
         nan_seen     = 1'b0;
         mean_divisor = '0;
         fail_count   = 0;
         owed_means.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            mean_divisor = csr_ch.average_count;
         if (req_ch.valid && req_ch.ready)
            accumulate_pair(req_ch.reference_value, req_ch.evaluated_value,
                            req_ch.last_element);
         if (rsp_ch.valid && rsp_ch.ready)
            check_result();
      end
      pending = owed_means.size();
   end

endmodule

FILE: test/mean_relative_difference_tb.sv
// top of the mean relative difference testbench: clock, reset, pair and count stimulus,
// random back-pressure on results, and the verdict
// depends on mrd_pkg, mrd_if, the mean_relative_difference rtl and mrd_checker
module mean_relative_difference_tb;

   typedef logic signed [mrd_pkg::DEFAULT_DATA_WIDTH-1:0] sample_type;

   localparam int         CNT_W       = mrd_pkg::CFG_WIDTH;
   localparam sample_type S_MIN       = 32'h8000_0000;
   localparam sample_type S_MAX       = 32'h7fff_ffff;
   localparam int         Q_ONE       = 32'h0001_0000;
   localparam int         RAND_PAIRS  = 1400;
   localparam int         DRAIN       = 100;
   localparam int         CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset;
   bit   quiet;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;

   mrd_req_if req_ch ();
   mrd_rsp_if rsp_ch ();
   mrd_csr_if csr_ch ();

   mean_relative_difference DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   mrd_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // offer one pair beat after a random gap, return once it is taken
   task automatic send_pair(input sample_type ref_s, input sample_type eval_s,
                            input logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.reference_value <= ref_s;
      req_ch.evaluated_value <= eval_s;
      req_ch.last_element    <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // let the block go idle: nothing owed and its pipeline drained
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // count register beat, only while idle
   task automatic write_count(input logic [CNT_W-1:0] count);
      settle();
      @(negedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.average_count <= count;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic sample_type extreme_sample();
      case ($urandom_range(0, 4))
         0:       return S_MIN;
         1:       return S_MAX;
         2:       return '0;
         3:       return 1;
         default: return -1;
      endcase
   endfunction

   // pair mix: mostly nearby values, some wild, zero-sum and extreme pairs
   task automatic random_pair(output sample_type ref_s, output sample_type eval_s);
      sample_type delta;
      int         kind;
      kind  = $urandom_range(0, 15);
      ref_s = $urandom >> $urandom_range(1, 31);
      if ($urandom_range(0, 1)) ref_s = -ref_s;
      delta = $urandom >> $urandom_range(4, 31);
      if ($urandom_range(0, 1)) delta = -delta;
      if (kind <= 6) begin
         eval_s = ref_s + delta;
      end else if (kind <= 9) begin
         ref_s  = $urandom;
         eval_s = $urandom;
      end else if (kind == 10) begin
         eval_s = ($urandom_range(0, 3) == 0) ? -ref_s : ref_s;
      end else if (kind == 11) begin
         eval_s = ref_s;
      end else if (kind == 12) begin
         // tiny sum, large ratio
         delta  = $urandom_range(1, 255);
         eval_s = $urandom_range(0, 1) ? -ref_s + delta : -ref_s - delta;
      end else if (kind == 13) begin
         ref_s  = extreme_sample();
         eval_s = extreme_sample();
      end else if (kind == 14) begin
         ref_s  = '0;
         eval_s = $urandom;
      end else begin
         ref_s  = sample_type'($urandom_range(0, 6)) - 3;
         eval_s = sample_type'($urandom_range(0, 6)) - 3;
      end
   endtask

   // result side: random stall before each beat
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int               sent;
      int               phase;
      int               set_size;
      logic [CNT_W-1:0] count;
      sample_type       ref_s;
      sample_type       eval_s;
      reset                  = 1'b1;
      quiet                  = 1'b0;
      req_ch.valid           = 1'b0;
      req_ch.reference_value = '0;
      req_ch.evaluated_value = '0;
      req_ch.last_element    = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.average_count   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, count register at its reset value
      send_pair('0, '0, 1'b1);                       // zero divisor, zero difference
      send_pair(5, -5, 1'b1);                        // zero divisor, nonzero difference
      send_pair(Q_ONE, -Q_ONE, 1'b0);                // error stays for the set
      send_pair(Q_ONE, Q_ONE, 1'b1);
      send_pair(32'h4000_0000, -32'sh3fff_ffff, 1'b1); // ratio saturates
      send_pair(S_MIN, S_MIN, 1'b0);                 // field extremes
      send_pair(S_MAX, S_MIN, 1'b0);
      send_pair(S_MIN, S_MAX, 1'b0);
      send_pair(S_MAX, S_MAX, 1'b1);
      send_pair(Q_ONE, 32'h0001_8000, 1'b0);         // ordinary ratios
      send_pair(32'h0002_0000, Q_ONE, 1'b1);

      // count of one: mean too large
      write_count(CNT_W'(1));
      send_pair(32'h4000_0000, -32'sh3fff_ffff, 1'b0);
      send_pair(S_MAX, S_MIN, 1'b0);
      send_pair(1, 0, 1'b1);
      send_pair('0, 32'h0000_1000, 1'b0);
      send_pair('0, -32'sh0000_1000, 1'b0);
      send_pair(S_MAX, -S_MAX, 1'b1);

      // count above the element limit, then exactly at it
      write_count('1);
      send_pair(1, 3, 1'b0);
      send_pair(-7, -9, 1'b1);
      write_count(CNT_W'(mrd_pkg::DEFAULT_MAX_ELEMENTS));
      send_pair(32'h4000_0000, -32'sh3fff_ffff, 1'b1);

      // random data sets over a round of count settings
      sent  = 0;
      phase = 0;
      while (sent < RAND_PAIRS) begin
         case (phase % 7)
            0:       count = '0;
            1:       count = CNT_W'(1);
            2:       count = CNT_W'($urandom_range(2, 8));
            3:       count = CNT_W'($urandom_range(9, 4096));
            4:       count = CNT_W'($urandom_range(4097, 2097151));
            5:       count = '1;
            default: count = CNT_W'(mrd_pkg::DEFAULT_MAX_ELEMENTS);
         endcase
         write_count(count);
         quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(8, 20)) begin
            set_size = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
            for (int i = 0; i < set_size; i++) begin
               random_pair(ref_s, eval_s);
               send_pair(ref_s, eval_s, i == set_size - 1);
            end
            sent += set_size;
         end
         phase++;
      end

      settle();
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
